/* hw/rtl/csq_pkg.sv */
// Package for the cursor sequence store: request, status and cell operation codes,
// default sizes and fixed port widths. No dependencies.
package csq_pkg;

	localparam int CAPACITY_DEF   = 64;
	localparam int WORD_WIDTH_DEF = 32;

	localparam int REQ_W    = 3;
	localparam int ENTRY_W  = 32;
	localparam int VALUE_W  = 32;
	localparam int COUNT_W  = 7;
	localparam int STATUS_W = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_START   = 3'd0,
		REQ_ADVANCE = 3'd1,
		REQ_INSERT  = 3'd2,
		REQ_ATTACH  = 3'd3,
		REQ_REMOVE  = 3'd4,
		REQ_READ    = 3'd5
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_NOCUR = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2
	} cell_op_t;

endpackage

/* hw/rtl/csq_cell.sv */
// One storage cell of the word chain: holds one word, loads the new word at the insert position
// and takes its neighbour's word on a shift. Depends on csq_pkg.
module csq_cell #(
	parameter int IDX        = 0,
	parameter int POS_W      = 6,
	parameter int WORD_WIDTH = 32
) (
	input  logic                  clk,
	input  csq_pkg::cell_op_t     op,
	input  logic [POS_W-1:0]      pos,
	input  logic [POS_W-1:0]      cursor,
	input  logic [WORD_WIDTH-1:0] new_word,
	input  logic [WORD_WIDTH-1:0] left_word,
	input  logic [WORD_WIDTH-1:0] right_word,
	output logic [WORD_WIDTH-1:0] word,
	output logic [WORD_WIDTH-1:0] sel_word
);
	import csq_pkg::*;

	localparam logic [POS_W-1:0] IDX_P = POS_W'(IDX);

	logic [WORD_WIDTH-1:0] word_q;

	always_ff @(posedge clk) begin
		case (op)
			OP_INSERT: begin
				if (IDX_P > pos) begin
					word_q <= left_word;
				end else if (IDX_P == pos) begin
					word_q <= new_word;
				end
			end
			OP_REMOVE: begin
				if (IDX_P >= pos) begin
					word_q <= right_word;
				end
			end
			default: begin
			end
		endcase
	end

	assign word     = word_q;
	assign sel_word = (IDX_P == cursor) ? word_q : '0;

endmodule

/* hw/rtl/cursor_sequence_store_top.sv */
// Top level of the cursor sequence store: request decode, count and cursor registers,
// and the chain of csq_cell word cells. Depends on csq_pkg and csq_cell.
// The result strobe (done) is a register set by the accepting edge.
// One request per cycle is taken; busy stays low, and all words shift together on the accepting edge.
// Reset clears the word count and the cursor; the cells' words are not reset.
// done cannot be held off: a result is taken in the one cycle it is shown.
module cursor_sequence_store_top #(
	parameter int CAPACITY   = csq_pkg::CAPACITY_DEF,
	parameter int WORD_WIDTH = csq_pkg::WORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [csq_pkg::REQ_W-1:0]     req_type,
	input  logic [csq_pkg::ENTRY_W-1:0]   entry_value,
	output logic                          done,
	output logic [csq_pkg::VALUE_W-1:0]   current_value,
	output logic                          has_current,
	output logic [csq_pkg::COUNT_W-1:0]   item_count,
	output logic [csq_pkg::STATUS_W-1:0]  status
);
	import csq_pkg::*;

	localparam int POS_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic                  accept;
	logic [CNT_W-1:0]      cnt_q, cnt_d;
	logic [POS_W-1:0]      cp_q, cp_d;
	logic                  cv_q, cv_d;
	status_t               st_q, st_d;
	logic                  done_q;
	cell_op_t              op_d, cell_op;
	logic [POS_W-1:0]      pos_d;
	logic [CNT_W-1:0]      cp_ext, cp_inc, ins_pos;
	logic [WORD_WIDTH-1:0] new_word;
	logic [WORD_WIDTH-1:0] sel_or;

	logic [WORD_WIDTH-1:0] cell_word  [CAPACITY];
	logic [WORD_WIDTH-1:0] cell_left  [CAPACITY];
	logic [WORD_WIDTH-1:0] cell_right [CAPACITY];
	logic [WORD_WIDTH-1:0] cell_sel   [CAPACITY];

	assign busy     = 1'b0;
	assign accept   = start && !busy;
	assign cp_ext   = CNT_W'(cp_q);
	assign cp_inc   = cp_ext + CNT_W'(1);
	assign new_word = WORD_WIDTH'(entry_value);

	always_comb begin
		op_d    = OP_HOLD;
		pos_d   = cp_q;
		cnt_d   = cnt_q;
		cp_d    = cp_q;
		cv_d    = cv_q;
		st_d    = ST_OK;
		ins_pos = '0;
		case (req_t'(req_type))
			REQ_START: begin
				cp_d = '0;
				cv_d = (cnt_q != '0);
			end
			REQ_ADVANCE: begin
				if (!cv_q) begin
					st_d = ST_NOCUR;
				end else if (cp_inc >= cnt_q) begin
					cv_d = 1'b0;
					cp_d = '0;
				end else begin
					cp_d = POS_W'(cp_inc);
				end
			end
			REQ_INSERT, REQ_ATTACH: begin
				if (cnt_q == CNT_W'(CAPACITY)) begin
					st_d = ST_FULL;
				end else begin
					if (req_t'(req_type) == REQ_INSERT) begin
						ins_pos = cv_q ? cp_ext : '0;
					end else begin
						ins_pos = cv_q ? cp_inc : cnt_q;
					end
					op_d  = OP_INSERT;
					pos_d = POS_W'(ins_pos);
					cnt_d = cnt_q + CNT_W'(1);
					cp_d  = POS_W'(ins_pos);
					cv_d  = 1'b1;
				end
			end
			REQ_REMOVE: begin
				if (!cv_q || cp_ext >= cnt_q) begin
					st_d = ST_NOCUR;
				end else begin
					op_d  = OP_REMOVE;
					pos_d = cp_q;
					cnt_d = cnt_q - CNT_W'(1);
					if (cp_inc >= cnt_q) begin
						cv_d = 1'b0;
						cp_d = '0;
					end
				end
			end
			default: begin
				if (!cv_q) begin
					st_d = ST_NOCUR;
				end
			end
		endcase
	end

	assign cell_op = accept ? op_d : OP_HOLD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			cp_q   <= '0;
			cv_q   <= 1'b0;
			st_q   <= ST_OK;
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				cnt_q <= cnt_d;
				cp_q  <= cp_d;
				cv_q  <= cv_d;
				st_q  <= st_d;
			end
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign cell_left[i] = '0;
		end else begin : g_mid_l
			assign cell_left[i] = cell_word[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign cell_right[i] = '0;
		end else begin : g_mid_r
			assign cell_right[i] = cell_word[i+1];
		end

		csq_cell #(
			.IDX        (i),
			.POS_W      (POS_W),
			.WORD_WIDTH (WORD_WIDTH)
		) u_cell (
			.clk        (clk),
			.op         (cell_op),
			.pos        (pos_d),
			.cursor     (cp_q),
			.new_word   (new_word),
			.left_word  (cell_left[i]),
			.right_word (cell_right[i]),
			.word       (cell_word[i]),
			.sel_word   (cell_sel[i])
		);
	end

	always_comb begin
		sel_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			sel_or = sel_or | cell_sel[i];
		end
	end

	assign done          = done_q;
	assign has_current   = cv_q && (cp_ext < cnt_q);
	assign current_value = has_current ? VALUE_W'(sel_or) : '0;
	assign item_count    = COUNT_W'(cnt_q);
	assign status        = st_q;

endmodule

/* hw/rtl/csq_checker.sv */
// Port-level checks for cursor_sequence_store_top, attached by the bind at the end.
// Depends on csq_pkg and the top level's ports.
module csq_port_checks (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic [csq_pkg::REQ_W-1:0]     req_type,
	input logic                          done,
	input logic [csq_pkg::VALUE_W-1:0]   current_value,
	input logic                          has_current,
	input logic [csq_pkg::COUNT_W-1:0]   item_count,
	input logic [csq_pkg::STATUS_W-1:0]  status
);
	import csq_pkg::*;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("transaction accepted without a result in the next cycle");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result strobe without an accepted transaction");

	a_no_cursor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !has_current) |-> (current_value == '0))
		else $error("word reported without a cursor");

	a_nocur_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_NOCUR) |-> !has_current)
		else $error("no-cursor status while a cursor exists");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (req_type == REQ_INSERT || req_type == REQ_ATTACH))
		|=> (status == ST_FULL || has_current))
		else $error("insert succeeded without placing the cursor");

endmodule

bind cursor_sequence_store_top csq_port_checks u_port_checks (.*);
